// ===== rtl/pvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared constants, register indexes and a term helper for the Phong shader.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int UNIT_BITS = 16;
  localparam int TERM_BITS = 16;
  localparam int MAG_BITS  = 15;
  localparam int COLOR_BITS = 24;
  localparam int SHINE_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [TERM_BITS-1:0] TERM_MAX = 16'hFFFF;

  localparam logic [COLOR_BITS-1:0] AMBIENT_RESET  = 24'h1A1A1A;
  localparam logic [COLOR_BITS-1:0] DIFFUSE_RESET  = 24'h808080;
  localparam logic [COLOR_BITS-1:0] SPECULAR_RESET = 24'hFFFFFF;
  localparam logic [SHINE_BITS-1:0] SHININESS_RESET = 8'd32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_AMBIENT   = 2'd0,
    REG_DIFFUSE   = 2'd1,
    REG_SPECULAR  = 2'd2,
    REG_SHININESS = 2'd3
  } cfg_reg_t;

  typedef logic [2:0][UNIT_BITS-1:0] unit_vec_t;

  // clamp a Q2.30 dot to an unsigned Q0.16 term
  function automatic logic [TERM_BITS-1:0] to_term(input logic signed [39:0] d);
    logic [39:0] t;
    begin
      t = 40'(d >>> 14);
      if (d <= 40'sd0) begin
        to_term = '0;
      end else if (t > 40'(TERM_MAX)) begin
        to_term = TERM_MAX;
      end else begin
        to_term = t[TERM_BITS-1:0];
      end
    end
  endfunction

endpackage

// ===== rtl/pvs_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_normalize
// Pipelined unit-vector unit: block shift, sum of squares, bit-serial square
// root (one step per stage) and restoring divide (one quotient bit per stage).
// ----------------------------------------------------------------------------
module pvs_normalize
  import pvs_pkg::*;
#(
  parameter int VECTOR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [2:0][VECTOR_BITS-1:0] raw,
  output logic                        out_valid,
  output unit_vec_t                   unit
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 17;
  localparam int REM_BITS  = 48;
  localparam int LEN_BITS  = 31;

  // stage A: magnitudes
  logic                        a_valid;
  logic [2:0]                  a_neg;
  logic [2:0][VECTOR_BITS-1:0] a_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      a_neg[i] <= raw[i][VECTOR_BITS-1];
      a_mag[i] <= raw[i][VECTOR_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  // stage B: common shift so the largest magnitude lands in [2^14, 2^15)
  logic [VECTOR_BITS-1:0]          b_or;
  logic [5:0]                      b_pos;
  logic [2:0][MAG_BITS-1:0]        b_shift;
  logic [VECTOR_BITS+MAG_BITS-1:0] b_wide;

  always_comb begin
    b_or  = a_mag[0] | a_mag[1] | a_mag[2];
    b_pos = '0;
    for (int b = 0; b < VECTOR_BITS; b++) begin
      if (b_or[b]) begin
        b_pos = 6'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      b_wide = {{MAG_BITS{1'b0}}, a_mag[i]};
      if (b_pos >= 6'd14) begin
        b_wide = b_wide >> (b_pos - 6'd14);
      end else begin
        b_wide = b_wide << (6'd14 - b_pos);
      end
      b_shift[i] = b_wide[MAG_BITS-1:0];
    end
  end

  logic                     b_valid;
  logic                     b_zero;
  logic [2:0]               b_neg;
  logic [2:0][MAG_BITS-1:0] b_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_zero <= (b_or == '0);
    b_neg  <= a_neg;
    b_mag  <= b_shift;
  end

  // stage C: squares
  logic                     c_valid;
  logic                     c_zero;
  logic [2:0]               c_neg;
  logic [2:0][MAG_BITS-1:0] c_mag;
  logic [2:0][29:0]         c_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_zero <= b_zero;
    c_neg  <= b_neg;
    c_mag  <= b_mag;
    for (int i = 0; i < 3; i++) begin
      c_sq[i] <= b_mag[i] * b_mag[i];
    end
  end

  // square root pipeline, entry is the scaled sum
  logic [SQ_STEPS:0]                 sq_valid;
  logic [SQ_STEPS:0]                 sq_zero;
  logic [SQ_STEPS:0][2:0]            sq_neg;
  logic [SQ_STEPS:0][2:0][MAG_BITS-1:0] sq_mag;
  logic [SQ_STEPS:0][63:0]           sq_v;
  logic [SQ_STEPS:0][63:0]           sq_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else begin
      sq_valid[0] <= c_valid;
    end
    sq_zero[0] <= c_zero;
    sq_neg[0]  <= c_neg;
    sq_mag[0]  <= c_mag;
    sq_v[0]    <= {2'b00, (32'(c_sq[0]) + 32'(c_sq[1]) + 32'(c_sq[2])), 30'b0};
    sq_res[0]  <= '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sq_res[k] + SQ_BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else begin
        sq_valid[k+1] <= sq_valid[k];
      end
      sq_zero[k+1] <= sq_zero[k];
      sq_neg[k+1]  <= sq_neg[k];
      sq_mag[k+1]  <= sq_mag[k];
      if (sq_v[k] >= trial) begin
        sq_v[k+1]   <= sq_v[k] - trial;
        sq_res[k+1] <= (sq_res[k] >> 1) + SQ_BIT;
      end else begin
        sq_v[k+1]   <= sq_v[k];
        sq_res[k+1] <= sq_res[k] >> 1;
      end
    end
  end

  // divide pipeline, three lanes share the length
  logic [DIV_STEPS:0]                   dv_valid;
  logic [DIV_STEPS:0]                   dv_zero;
  logic [DIV_STEPS:0][2:0]              dv_neg;
  logic [DIV_STEPS:0][LEN_BITS-1:0]     dv_len;
  logic [DIV_STEPS:0][2:0][REM_BITS-1:0] dv_rem;
  logic [DIV_STEPS:0][2:0][DIV_STEPS-1:0] dv_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[SQ_STEPS];
    end
    dv_zero[0] <= sq_zero[SQ_STEPS];
    dv_neg[0]  <= sq_neg[SQ_STEPS];
    dv_len[0]  <= sq_res[SQ_STEPS][LEN_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= {3'b000, sq_mag[SQ_STEPS][i], 30'b0};
      dv_q[0][i]   <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int DB = DIV_STEPS - 1 - j;
    logic [REM_BITS-1:0] den;
    assign den = REM_BITS'(dv_len[j]) << DB;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else begin
        dv_valid[j+1] <= dv_valid[j];
      end
      dv_zero[j+1] <= dv_zero[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_len[j+1]  <= dv_len[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j][i] >= den) begin
          dv_rem[j+1][i] <= dv_rem[j][i] - den;
          dv_q[j+1][i]   <= dv_q[j][i] | (DIV_STEPS'(1) << DB);
        end else begin
          dv_rem[j+1][i] <= dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i];
        end
      end
    end
  end

  // cap, sign and zero-length
  logic [2:0][UNIT_BITS-1:0] fin_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_q[DIV_STEPS][i] > DIV_STEPS'(32767)) begin
        fin_mag[i] = 16'd32767;
      end else begin
        fin_mag[i] = dv_q[DIV_STEPS][i][UNIT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[DIV_STEPS];
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[DIV_STEPS]) begin
        unit[i] <= '0;
      end else if (dv_neg[DIV_STEPS][i]) begin
        unit[i] <= -fin_mag[i];
      end else begin
        unit[i] <= fin_mag[i];
      end
    end
  end

endmodule

// ===== rtl/pvs_power.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_power
// Specular exponent: a chain of one truncating Q0.16 multiply per stage,
// enabled while the stage number is below the shininess. Diffuse rides along.
// ----------------------------------------------------------------------------
module pvs_power
  import pvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SHINE_BITS-1:0] shininess,
  input  logic                  in_valid,
  input  logic [TERM_BITS-1:0]  spec,
  input  logic [TERM_BITS-1:0]  diff,
  output logic                  out_valid,
  output logic [TERM_BITS-1:0]  pow,
  output logic [TERM_BITS-1:0]  diff_out
);

  localparam int STEPS = 254;

  logic [STEPS:0]                valid;
  logic [STEPS:0][TERM_BITS-1:0] base;
  logic [STEPS:0][TERM_BITS-1:0] acc;
  logic [STEPS:0][TERM_BITS-1:0] dterm;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    base[0]  <= spec;
    acc[0]   <= spec;
    dterm[0] <= diff;
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_mul
    logic [2*TERM_BITS-1:0] prod;
    assign prod = acc[k-1] * base[k-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else begin
        valid[k] <= valid[k-1];
      end
      base[k]  <= base[k-1];
      dterm[k] <= dterm[k-1];
      if (SHINE_BITS'(k) < shininess) begin
        acc[k] <= prod[2*TERM_BITS-1:TERM_BITS];
      end else begin
        acc[k] <= acc[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid[STEPS];
    end
    pow      <= (shininess == '0) ? TERM_MAX : acc[STEPS];
    diff_out <= dterm[STEPS];
  end

endmodule

// ===== rtl/phong_vertex_shader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phong_vertex_shader_unit
// Phong lighting of one vertex: normalize N, L, V; diffuse and powered
// specular terms; RGB = ambient + diffuse*dc + specular*sc, saturated.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start / busy       | normal_*, light_*, view_* (VECTOR_BITS)
//   result   | result_valid       | red, green, blue
//   config   | cfg_we             | cfg_addr, cfg_wdata
//
// One word is taken every clock; busy never rises. A word passes in order through
// the normalizers (32-step square root, 17-step divide), the dot-product and
// reflection stages, the exponent chain (254 multiply stages) and the color-mix
// stages. Reset clears all valid bits and loads the register defaults.
// Results appear for one cycle on result_valid.
// ----------------------------------------------------------------------------
module phong_vertex_shader_unit
  import pvs_pkg::*;
#(
  parameter int VECTOR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VECTOR_BITS-1:0] normal_x,
  input  logic signed [VECTOR_BITS-1:0] normal_y,
  input  logic signed [VECTOR_BITS-1:0] normal_z,
  input  logic signed [VECTOR_BITS-1:0] light_x,
  input  logic signed [VECTOR_BITS-1:0] light_y,
  input  logic signed [VECTOR_BITS-1:0] light_z,
  input  logic signed [VECTOR_BITS-1:0] view_x,
  input  logic signed [VECTOR_BITS-1:0] view_y,
  input  logic signed [VECTOR_BITS-1:0] view_z,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_addr,
  input  logic [COLOR_BITS-1:0]         cfg_wdata,
  output logic                          result_valid,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue
);

  assign busy = 1'b0;

  // configuration registers
  logic [COLOR_BITS-1:0] ambient_color;
  logic [COLOR_BITS-1:0] diffuse_color;
  logic [COLOR_BITS-1:0] specular_color;
  logic [SHINE_BITS-1:0] shininess;

  always_ff @(posedge clk) begin
    if (rst) begin
      ambient_color  <= AMBIENT_RESET;
      diffuse_color  <= DIFFUSE_RESET;
      specular_color <= SPECULAR_RESET;
      shininess      <= SHININESS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_AMBIENT:   ambient_color  <= cfg_wdata;
        REG_DIFFUSE:   diffuse_color  <= cfg_wdata;
        REG_SPECULAR:  specular_color <= cfg_wdata;
        REG_SHININESS: shininess      <= cfg_wdata[SHINE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // normalization
  logic      n_valid;
  logic      l_valid;
  logic      v_valid;
  unit_vec_t n_unit;
  unit_vec_t l_unit;
  unit_vec_t v_unit;

  pvs_normalize #(.VECTOR_BITS(VECTOR_BITS)) u_norm_n (
    .clk(clk), .rst(rst), .in_valid(start),
    .raw({normal_z, normal_y, normal_x}),
    .out_valid(n_valid), .unit(n_unit)
  );

  pvs_normalize #(.VECTOR_BITS(VECTOR_BITS)) u_norm_l (
    .clk(clk), .rst(rst), .in_valid(start),
    .raw({light_z, light_y, light_x}),
    .out_valid(l_valid), .unit(l_unit)
  );

  pvs_normalize #(.VECTOR_BITS(VECTOR_BITS)) u_norm_v (
    .clk(clk), .rst(rst), .in_valid(start),
    .raw({view_z, view_y, view_x}),
    .out_valid(v_valid), .unit(v_unit)
  );

  // N.L products
  logic               l1_valid;
  logic signed [31:0] l1_p [3];
  unit_vec_t          l1_n;
  unit_vec_t          l1_l;
  unit_vec_t          l1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
    end else begin
      l1_valid <= n_valid & l_valid & v_valid;
    end
    for (int i = 0; i < 3; i++) begin
      l1_p[i] <= $signed(n_unit[i]) * $signed(l_unit[i]);
    end
    l1_n <= n_unit;
    l1_l <= l_unit;
    l1_v <= v_unit;
  end

  // N.L sum
  logic               l2_valid;
  logic signed [33:0] l2_nl;
  unit_vec_t          l2_n;
  unit_vec_t          l2_l;
  unit_vec_t          l2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_valid <= 1'b0;
    end else begin
      l2_valid <= l1_valid;
    end
    l2_nl <= 34'(l1_p[0]) + 34'(l1_p[1]) + 34'(l1_p[2]);
    l2_n  <= l1_n;
    l2_l  <= l1_l;
    l2_v  <= l1_v;
  end

  // (N.L) * N and diffuse term
  logic                 l3_valid;
  logic signed [49:0]   l3_rp [3];
  logic [TERM_BITS-1:0] l3_diff;
  unit_vec_t            l3_l;
  unit_vec_t            l3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      l3_valid <= 1'b0;
    end else begin
      l3_valid <= l2_valid;
    end
    for (int i = 0; i < 3; i++) begin
      l3_rp[i] <= l2_nl * $signed(l2_n[i]);
    end
    l3_diff <= to_term(40'(l2_nl));
    l3_l    <= l2_l;
    l3_v    <= l2_v;
  end

  // reflected light, truncating toward zero
  logic signed [50:0] l4_t   [3];
  logic        [50:0] l4_abs [3];
  logic signed [19:0] l4_q   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l4_t[i]   = 51'(l3_rp[i]) <<< 1;
      l4_abs[i] = (l4_t[i] < 0) ? 51'(-l4_t[i]) : 51'(l4_t[i]);
      l4_q[i]   = (l4_t[i] < 0) ? -$signed(l4_abs[i][49:30]) : $signed(l4_abs[i][49:30]);
    end
  end

  logic                 l4_valid;
  logic signed [19:0]   l4_r [3];
  logic [TERM_BITS-1:0] l4_diff;
  unit_vec_t            l4_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      l4_valid <= 1'b0;
    end else begin
      l4_valid <= l3_valid;
    end
    for (int i = 0; i < 3; i++) begin
      l4_r[i] <= l4_q[i] - 20'($signed(l3_l[i]));
    end
    l4_diff <= l3_diff;
    l4_v    <= l3_v;
  end

  // R.V products
  logic                 l5_valid;
  logic signed [35:0]   l5_p [3];
  logic [TERM_BITS-1:0] l5_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      l5_valid <= 1'b0;
    end else begin
      l5_valid <= l4_valid;
    end
    for (int i = 0; i < 3; i++) begin
      l5_p[i] <= l4_r[i] * $signed(l4_v[i]);
    end
    l5_diff <= l4_diff;
  end

  // R.V sum and specular term
  logic                 l6_valid;
  logic [TERM_BITS-1:0] l6_spec;
  logic [TERM_BITS-1:0] l6_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      l6_valid <= 1'b0;
    end else begin
      l6_valid <= l5_valid;
    end
    l6_spec <= to_term(40'(l5_p[0]) + 40'(l5_p[1]) + 40'(l5_p[2]));
    l6_diff <= l5_diff;
  end

  // exponent
  logic                 pw_valid;
  logic [TERM_BITS-1:0] pw_spec;
  logic [TERM_BITS-1:0] pw_diff;

  pvs_power u_power (
    .clk(clk), .rst(rst), .shininess(shininess),
    .in_valid(l6_valid), .spec(l6_spec), .diff(l6_diff),
    .out_valid(pw_valid), .pow(pw_spec), .diff_out(pw_diff)
  );

  // color products
  logic             c1_valid;
  logic [2:0][23:0] c1_dp;
  logic [2:0][23:0] c1_sp;
  logic [2:0][7:0]  c1_amb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else begin
      c1_valid <= pw_valid;
    end
    for (int c = 0; c < 3; c++) begin
      c1_dp[c]  <= pw_diff * diffuse_color[8*c +: 8];
      c1_sp[c]  <= pw_spec * specular_color[8*c +: 8];
      c1_amb[c] <= ambient_color[8*c +: 8];
    end
  end

  // accumulate and saturate; channel 2 is red, 0 is blue
  logic [2:0][25:0] c2_acc;
  logic [2:0][7:0]  c2_out;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      c2_acc[c] = {2'b00, c1_amb[c], 16'b0} + 26'(c1_dp[c]) + 26'(c1_sp[c]);
      c2_out[c] = (c2_acc[c][25:24] != 2'b00) ? 8'hFF : c2_acc[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= c1_valid;
    end
    red   <= c2_out[2];
    green <= c2_out[1];
    blue  <= c2_out[0];
  end

endmodule
